>>> hdl/aep_pkg.sv
// ----------------------------------------------------------------------------
// aep_pkg: shared types and constants for the easing progress block
// Fixed-point widths, register indexes, easing codes and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package aep_pkg;

	localparam int FRAC_BITS = 16;

	localparam int TW  = 16;                 // time and duration width
	localparam int OW  = 17;                 // Q1.16 output width
	localparam int MDW = 3;                  // easing mode width
	localparam int CIW = 1;                  // config index width
	localparam int CDW = 16;                 // config data width

	localparam int VW  = FRAC_BITS + 1;      // eased value, up to ONE
	localparam int SW  = FRAC_BITS + 5;      // 22 * p
	localparam int MB  = FRAC_BITS + 3;      // squarer operand
	localparam int MD  = (MB + 1) / 2;       // radix-4 digits
	localparam int BW  = 2 * MD;
	localparam int PRW = 2 * MB;             // square width

	localparam int DCW = $clog2(FRAC_BITS + 1);
	localparam int MCW = $clog2(MD + 1);

	localparam logic [VW-1:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [VW-1:0] HALF   = ONE >> 1;
	localparam logic [VW-1:0] ADD_B2 = ONE - (ONE >> 2);
	localparam logic [VW-1:0] ADD_B3 = ONE - (ONE >> 4);
	localparam logic [VW-1:0] ADD_B4 = ONE - (ONE >> 6);

	localparam logic [SW-1:0] S8  = SW'(8) << FRAC_BITS;
	localparam logic [SW-1:0] S12 = SW'(12) << FRAC_BITS;
	localparam logic [SW-1:0] S16 = SW'(16) << FRAC_BITS;
	localparam logic [SW-1:0] S18 = SW'(18) << FRAC_BITS;
	localparam logic [SW-1:0] S20 = SW'(20) << FRAC_BITS;
	localparam logic [SW-1:0] S21 = SW'(21) << FRAC_BITS;

	localparam logic [PRW:0] BNC_RND = (PRW + 1)'(32) << FRAC_BITS;

	localparam logic [TW-1:0] DURATION_RST = TW'(1000);

	localparam logic [CIW-1:0] REG_DURATION = 1'd0;
	localparam logic [CIW-1:0] REG_MODE     = 1'd1;

	localparam logic [MDW-1:0] MODE_LINEAR = 3'd0;
	localparam logic [MDW-1:0] MODE_IN     = 3'd1;
	localparam logic [MDW-1:0] MODE_OUT    = 3'd2;
	localparam logic [MDW-1:0] MODE_INOUT  = 3'd3;
	localparam logic [MDW-1:0] MODE_BOUNCE = 3'd4;

	typedef struct packed {
		logic busy;
		logic done;
	} aep_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_MUL,
		ST_CURVE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

>>> hdl/aep_div.sv
// ----------------------------------------------------------------------------
// aep_div: bit-serial progress divider
// Restoring division, one quotient bit per cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module aep_div
	import aep_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [TW-1:0]        num,
	input  wire logic [TW-1:0]        den,
	output aep_sts_t                  sts,
	output logic      [FRAC_BITS-1:0] quo
);

	logic [TW-1:0]        rem_q;
	logic [TW-1:0]        den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [DCW-1:0]       cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TW:0]          r2;
	logic [TW:0]          diff;
	logic                 ge;

	assign r2   = {rem_q, 1'b0};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DCW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCW'(1);
				if (cnt_q == DCW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TW-1:0] : r2[TW-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

`default_nettype wire

>>> hdl/aep_mul.sv
// ----------------------------------------------------------------------------
// aep_mul: digit-serial squarer
// Radix-4 shift-add, two multiplier bits per cycle, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module aep_mul
	import aep_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [MB-1:0]  opnd,
	output aep_sts_t            sts,
	output logic      [PRW-1:0] prod
);

	logic [MB-1:0]  a_q;
	logic [BW-1:0]  b_q;
	logic [PRW-1:0] acc_q;
	logic [MCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [1:0]     dig;
	logic [MB+1:0]  pp;

	assign dig = b_q[BW-1 -: 2];
	assign pp  = (dig[0] ? {2'b00, a_q} : '0) + (dig[1] ? {1'b0, a_q, 1'b0} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == MCW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MCW'(MD);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MCW'(1);
				if (cnt_q == MCW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= opnd;
			b_q   <= BW'(opnd);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PRW-3:0], 2'b00} + PRW'(pp);
			b_q   <= {b_q[BW-3:0], 2'b00};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

`default_nettype wire

>>> hdl/animation_easing_progress.sv
// ----------------------------------------------------------------------------
// animation_easing_progress: eased animation progress per timer tick
//
// Input channel (in_valid/in_stall) carries elapsed_ms for one tick. Output
// channel (out_valid/out_stall) returns eased_progress in Q1.16 and done_res.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 duration_ms,
// 1 easing_mode); write only while no transaction is in flight.
//
// A normal tick runs the bit-serial divider, a prep step, the radix-4
// squarer, a curve step and the output step (ST_DIV, ST_PREP, ST_MUL,
// ST_CURVE, ST_EMIT) from accept to out_valid. A tick that reaches the
// duration skips to the output step and returns 1.0 with done_res set;
// ticks after that give no transaction until reset. One tick is in work
// at a time: the next tick is not taken until the current one leaves the
// output step; the divider and squarer loops take the most time.
// in_stall is low only while idle. A result held by out_stall does not block
// acceptance of the next tick, which waits for the output register only at
// its own end. Reset restores duration 1000 ms, linear mode, not finished.
// ----------------------------------------------------------------------------
`default_nettype none

module animation_easing_progress
	import aep_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [CIW-1:0] cfg_index,
	input  wire logic [CDW-1:0] cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [TW-1:0]  elapsed_ms,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic      [OW-1:0]  eased_progress,
	output logic                done_res
);

	state_t         state_q, state_d;
	logic [TW-1:0]  duration_q;
	logic [MDW-1:0] mode_q;
	logic           fin_q;
	logic           rdone_q;
	logic [VW-1:0]  v_q;
	logic [VW-1:0]  add_q;
	logic           out_valid_q;
	logic [OW-1:0]  out_val_q;
	logic           out_done_q;

	logic           in_acc;
	logic           reach;
	logic           div_start, mul_start;
	logic           ld_fin, ld_curve, ld_out;
	aep_sts_t       div_sts, mul_sts;
	logic [FRAC_BITS-1:0] p;
	logic [PRW-1:0] prod;

	logic [VW-1:0]  pe, q;
	logic [SW-1:0]  s, cs, w;
	logic [VW-1:0]  add_d;
	logic [MB-1:0]  opnd;

	logic [PRW:0]   sum1, sum4;
	logic [PRW+1:0] sum3;
	logic [VW-1:0]  t1, t3, t4;
	logic [VW:0]    v4;
	logic [VW-1:0]  v_d;
	logic [VW+TW:0] qsum;

	assign in_acc = in_valid && !in_stall;
	assign reach  = (elapsed_ms >= duration_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DURATION_RST;
			mode_q     <= MODE_LINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DURATION: duration_q <= cfg_wdata[TW-1:0];
				REG_MODE:     mode_q     <= cfg_wdata[MDW-1:0];
				default:      ;
			endcase
		end
	end

	aep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_ms),
		.den    (duration_q),
		.sts    (div_sts),
		.quo    (p)
	);

	// operand for the squarer, bounce segment offset
	assign pe = {1'b0, p};
	assign q  = ONE - pe;
	assign s  = (SW'(p) << 4) + (SW'(p) << 2) + (SW'(p) << 1);

	always_comb begin
		if (s < S8) begin
			cs    = '0;
			add_d = '0;
		end else if (s < S16) begin
			cs    = S12;
			add_d = ADD_B2;
		end else if (s < S20) begin
			cs    = S18;
			add_d = ADD_B3;
		end else begin
			cs    = S21;
			add_d = ADD_B4;
		end
		w = (s >= cs) ? s - cs : cs - s;
	end

	always_comb begin
		case (mode_q)
			MODE_OUT:    opnd = MB'(q);
			MODE_INOUT:  opnd = (pe < HALF) ? MB'(pe) : MB'(q);
			MODE_BOUNCE: opnd = w[MB-1:0];
			default:     opnd = MB'(pe);
		endcase
	end

	aep_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.opnd   (opnd),
		.sts    (mul_sts),
		.prod   (prod)
	);

	// curve from the square
	assign sum1 = {1'b0, prod} + (PRW + 1)'(HALF);
	assign sum3 = {1'b0, prod, 1'b0} + (PRW + 2)'(HALF);
	assign sum4 = {1'b0, prod} + BNC_RND;
	assign t1   = sum1[FRAC_BITS +: VW];
	assign t3   = sum3[FRAC_BITS +: VW];
	assign t4   = sum4[FRAC_BITS + 6 +: VW];
	assign v4   = {1'b0, t4} + {1'b0, add_q};

	always_comb begin
		case (mode_q)
			MODE_IN:     v_d = t1;
			MODE_OUT:    v_d = ONE - t1;
			MODE_INOUT:  v_d = (pe < HALF) ? t3 : ONE - t3;
			MODE_BOUNCE: v_d = (v4 > {1'b0, ONE}) ? ONE : v4[VW-1:0];
			default:     v_d = pe;
		endcase
	end

	assign qsum = {1'b0, v_q, {TW{1'b0}}} + (VW + TW + 1)'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		ld_fin    = 1'b0;
		ld_curve  = 1'b0;
		ld_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_acc && !fin_q) begin
					if (reach) begin
						ld_fin  = 1'b1;
						state_d = ST_EMIT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_sts.done)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_sts.done)
					state_d = ST_CURVE;
			end
			ST_CURVE: begin
				ld_curve = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_fin)
				fin_q <= 1'b1;
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_fin) begin
			v_q     <= ONE;
			rdone_q <= 1'b1;
		end else if (ld_curve) begin
			v_q     <= v_d;
			rdone_q <= 1'b0;
		end
		if (mul_start)
			add_q <= add_d;
		if (ld_out) begin
			out_val_q  <= qsum[FRAC_BITS +: OW];
			out_done_q <= rdone_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign eased_progress = out_val_q;
	assign done_res       = out_done_q;

`ifndef SYNTHESIS
	a_done_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> eased_progress == OW'(65536))
		else $error("done transaction without full progress");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> eased_progress <= OW'(65536))
		else $error("eased progress above one");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag cleared without reset");

	a_done_sets_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && done_res |-> fin_q)
		else $error("done transaction while not finished");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_sts.busy && !mul_sts.busy)
		else $error("serial unit busy while idle");
`endif

endmodule

`default_nettype wire

>>> sim/animation_easing_progress_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// animation_easing_progress_test: self-checking bench for the easing block
// A short stimulus table covers reset values, every curve, the bounce knees,
// an unused mode and duration extremes. It is followed by random phases, each
// with its own duration and mode. Every transaction on the output is checked
// against a bit-exact predictor of progress, curve and Q1.16 rounding. The
// zero-duration finish and the ignored ticks after it close the run.
// ----------------------------------------------------------------------------

module animation_easing_progress_test
	import aep_pkg::*;
();

	localparam int unsigned LIMIT        = 400000;
	localparam int unsigned PHASES       = 20;
	localparam int unsigned PHASE_ITEMS  = 56;
	localparam int unsigned SETTLE       = 40;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef enum bit {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CIW-1:0]   idx;
		logic [CDW-1:0]   data;
		logic [TW-1:0]    t;
		bit               has_exp;
		logic [OW-1:0]    ev;
		logic             ed;
	} row_t;

	typedef struct packed {
		logic [OW-1:0] v;
		logic          d;
	} ease_t;

	localparam int DIR_ROWS = 31;
	localparam row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd999,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd500,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_MODE,     CDW'(MODE_IN),      16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd500,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd999,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_MODE,     CDW'(MODE_OUT),     16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd999,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_MODE,     CDW'(MODE_INOUT),   16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd499,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd500,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd999,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_MODE,     CDW'(MODE_BOUNCE),  16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd363,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd364,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd727,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd728,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd909,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd910,   1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd999,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_MODE,     16'hFFFF,           16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd123,   1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_DURATION, 16'd65535,          16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd65534, 1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd32768, 1'b0, 17'd0, 1'b0},
		'{ROW_CFG,  REG_DURATION, 16'd1,              16'd0,     1'b0, 17'd0, 1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd0, 1'b0}
	};

	// zero duration finishes at once; later ticks must be dropped
	localparam int CLOSE_ROWS = 5;
	localparam row_t CLOSE_TAB [CLOSE_ROWS] = '{
		'{ROW_CFG,  REG_DURATION, 16'd0,              16'd0,     1'b0, 17'd0,     1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b1, 17'd65536, 1'b1},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd65535, 1'b0, 17'd0,     1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd0,     1'b0, 17'd0,     1'b0},
		'{ROW_TICK, REG_DURATION, 16'd0,              16'd777,   1'b0, 17'd0,     1'b0}
	};

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [CIW-1:0] cfg_index;
	logic [CDW-1:0] cfg_wdata;
	logic           in_valid;
	logic           in_stall;
	logic [TW-1:0]  elapsed_ms;
	logic           out_valid;
	logic           out_stall;
	logic [OW-1:0]  eased_progress;
	logic           done_res;

	logic [TW-1:0]  mdl_dur;
	logic [MDW-1:0] m_mode;
	bit             mdl_over;

	ease_t          pending_ease [$];
	ease_t          want;
	int unsigned    errors;
	int unsigned    tx_idle_pct;
	int unsigned    rx_idle_pct;
	bit             hold_req;
	int unsigned    hold_left;
	int unsigned    cycle_cnt;

	animation_easing_progress dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.elapsed_ms     (elapsed_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.eased_progress (eased_progress),
		.done_res       (done_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit ease_tick(input logic [TW-1:0] t, output ease_t res);
		bit [63:0] one, p, q, s, c, add, w, e;
		one = 64'd1 << FRAC_BITS;
		res = '0;
		if (mdl_over)
			return 1'b0;
		if (t >= mdl_dur) begin
			mdl_over = 1'b1;
			res.v = 17'd65536;
			res.d = 1'b1;
			return 1'b1;
		end
		p = (64'(t) << FRAC_BITS) / 64'(mdl_dur);
		q = one - p;
		case (m_mode)
			MODE_IN: e = (p * p + (one >> 1)) >> FRAC_BITS;
			MODE_OUT: e = one - ((q * q + (one >> 1)) >> FRAC_BITS);
			MODE_INOUT: begin
				if (p < (one >> 1))
					e = (2 * p * p + (one >> 1)) >> FRAC_BITS;
				else
					e = one - ((2 * q * q + (one >> 1)) >> FRAC_BITS);
			end
			MODE_BOUNCE: begin
				s = 22 * p;
				if (s < 8 * one) begin
					c = 0;
					add = 0;
				end else if (s < 16 * one) begin
					c = 12;
					add = (3 * one) >> 2;
				end else if (s < 20 * one) begin
					c = 18;
					add = (15 * one) >> 4;
				end else begin
					c = 21;
					add = (63 * one) >> 6;
				end
				w = (s >= c * one) ? s - c * one : c * one - s;
				e = ((w * w + 32 * one) >> (FRAC_BITS + 6)) + add;
				if (e > one)
					e = one;
			end
			default: e = p;
		endcase
		e = ((e << 16) + (one >> 1)) >> FRAC_BITS;
		res.v = e[OW-1:0];
		return 1'b1;
	endfunction

	// biased toward the ends, the ease-in-out midpoint, the bounce knees and the bounce segment centres
	function automatic logic [TW-1:0] pick_elapsed(input logic [TW-1:0] dur);
		int unsigned top, e, k;
		top = dur - 1;
		k = 0;
		case ($urandom_range(0, 9))
			0: e = 0;
			1: e = top;
			2: e = dur / 2;
			3: e = (dur >= 2) ? dur / 2 - 1 : 0;
			4, 5: begin
				case ($urandom_range(0, 5))
					0: k = 8;
					1: k = 12;
					2: k = 16;
					3: k = 18;
					4: k = 20;
					default: k = 21;
				endcase
				e = dur * k / 22 + $urandom_range(0, 1);
			end
			default: e = $urandom_range(0, top);
		endcase
		if (e > top)
			e = top;
		return TW'(e);
	endfunction

	task automatic send_tick(input logic [TW-1:0] t, input bit has_exp,
		input logic [OW-1:0] ev, input logic ed);
		ease_t res;
		in_valid <= 1'b1;
		elapsed_ms <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (ease_tick(t, res)) begin
			if (has_exp) begin
				res.v = ev;
				res.d = ed;
			end
			pending_ease.insert(pending_ease.size(), res);
		end
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (pending_ease.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DURATION: mdl_dur = data;
			REG_MODE: m_mode = data[MDW-1:0];
			default: ;
		endcase
	endtask

	task automatic run_row(input row_t r);
		if (r.kind == ROW_CFG) begin
			drain_results();
			write_reg(r.idx, r.data);
		end else begin
			send_tick(r.t, r.has_exp, r.ev, r.ed);
		end
	endtask

	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ease.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: eased_progress %0d done_res %0b",
					$time, eased_progress, done_res);
			end else begin
				want = pending_ease.pop_front();
				if (eased_progress !== want.v) begin
					errors++;
					$display("%0t eased_progress: expected %0d, actual %0d",
						$time, want.v, eased_progress);
				end
				if (done_res !== want.d) begin
					errors++;
					$display("%0t done_res: expected %0b, actual %0b",
						$time, want.d, done_res);
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d transactions outstanding",
			cycle_cnt, pending_ease.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [TW-1:0]  dur;
		logic [CDW-1:0] word;
		int unsigned    ph, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		elapsed_ms = '0;
		errors = 0;
		hold_req = 1'b0;
		mdl_dur = DURATION_RST;
		m_mode = MODE_LINEAR;
		mdl_over = 1'b0;
		tx_idle_pct = 17;
		rx_idle_pct = 55;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			run_row(DIR_TAB[i]);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 7) begin
				tx_idle_pct = 55;
				rx_idle_pct = 17;
			end else if (ph == 14) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			drain_results();
			case (ph % 5)
				0: dur = 16'd65535;
				1: dur = TW'($urandom_range(1, 16));
				3: dur = TW'($urandom_range(1000, 5000));
				default: dur = TW'($urandom_range(1, 65535));
			endcase
			write_reg(REG_DURATION, dur);
			word = CDW'($urandom);
			word[MDW-1:0] = MDW'(ph % 8);
			write_reg(REG_MODE, word);
			// receiver holds off while ticks keep coming
			if (ph == 3)
				hold_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 10 && n == PHASE_ITEMS / 2)
					drain_results();
				send_tick(pick_elapsed(mdl_dur), 1'b0, '0, 1'b0);
			end
		end

		for (int i = 0; i < CLOSE_ROWS; i++)
			run_row(CLOSE_TAB[i]);
		drain_results();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> animation_easing_progress.f
hdl/aep_pkg.sv
hdl/aep_div.sv
hdl/aep_mul.sv
hdl/animation_easing_progress.sv
sim/animation_easing_progress_test.sv
